// File: design/cordic_atan2_degrees_macros.svh
// assertion helpers shared by the design files
`ifndef CORDIC_ATAN2_DEGREES_MACROS_SVH
`define CORDIC_ATAN2_DEGREES_MACROS_SVH

// condition must hold at every edge outside reset
`define CAD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("cad invariant violated");

// antecedent at one edge implies consequent at the next edge
`define CAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cad next-cycle check failed");

`endif

// File: design/cad_pkg.sv
package cad_pkg;

   // signed working width of the vector components (covers cordic gain)
   localparam int XW = 24;
   // signed width of the angle accumulator, 11.16 degrees
   localparam int SW = 27;
   // width of the folded, non-negative angle
   localparam int FW = 25;

   localparam int IN_W  = 16;
   localparam int OUT_W = 16;

   localparam int ATAN_ENTRIES = 17;
   localparam int MAX_STEPS    = ATAN_ENTRIES - 1;

   localparam logic signed [SW-1:0] DEG_180 = SW'(180 * 65536);
   localparam logic signed [SW-1:0] DEG_360 = SW'(360 * 65536);

   // floor(v / 360) = floor((v >> 3) * DIV_MULT >> DIV_SHIFT) for v < 2^25
   localparam int DIV_SHIFT  = 28;
   localparam int DIV_IN_W   = FW - 3;
   localparam int DIV_MULT_W = 23;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT = 23'd5965233;
   localparam int PROD_W = DIV_IN_W + DIV_MULT_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_UNIT = 1'b0;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [SW-1:0] sum;
      logic                 dneg;     // current rotation direction is negative
      logic                 negated;  // x was mirrored at the input
      logic                 unit;     // turn units instead of degrees
   } cad_item_type;

   // arctangent of 2^-(i-1) in 11.16 degrees, entry 0 is the 90 degree pre-rotation
   function automatic logic signed [SW-1:0] atan_deg(input int unsigned idx);
      logic signed [SW-1:0] r;
      case (idx)
         0:       r = 27'sh5A0000;
         1:       r = 27'sh2d0000;
         2:       r = 27'sh1a90a7;
         3:       r = 27'she0947;
         4:       r = 27'sh72001;
         5:       r = 27'sh3938b;
         6:       r = 27'sh1ca38;
         7:       r = 27'she52a;
         8:       r = 27'sh7297;
         9:       r = 27'sh394c;
         10:      r = 27'sh1ca5;
         11:      r = 27'she52;
         12:      r = 27'sh729;
         13:      r = 27'sh394;
         14:      r = 27'sh1ca;
         15:      r = 27'she5;
         16:      r = 27'sh72;
         default: r = '0;
      endcase
      return r;
   endfunction

   // one micro-rotation with shift s
   function automatic cad_item_type cad_step(input cad_item_type a, input int unsigned s,
                                            input logic signed [SW-1:0] ang);
      cad_item_type         r;
      logic signed [XW-1:0] xsh;
      logic signed [XW-1:0] ysh;
      xsh = $signed(a.x) >>> s;
      ysh = $signed(a.y) >>> s;
      r = a;
      if (a.dneg) begin
         r.x   = a.x + ysh;
         r.y   = a.y - xsh;
         r.sum = a.sum - ang;
      end else begin
         r.x   = a.x - ysh;
         r.y   = a.y + xsh;
         r.sum = a.sum + ang;
      end
      r.dneg = r.y[XW-1];
      return r;
   endfunction

endpackage

// File: design/cad_if.sv
interface cad_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [cad_pkg::IN_W-1:0]  x_in;
   logic signed [cad_pkg::IN_W-1:0]  y_in;

   modport source (output valid, output x_in, output y_in, input ready);
   modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

interface cad_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cad_pkg::OUT_W-1:0]        angle_out;

   modport source (output valid, output angle_out, input ready);
   modport sink   (input valid, input angle_out, output ready);
endinterface

// File: design/cad_front.sv
module cad_front (
   input  logic                              clock,
   input  logic                              reset,
   cad_req_if.sink                           req_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cad_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [cad_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cad_pkg::CSR_DATA_W-1:0]    prdata,
   input  logic                              q_full,
   output logic                              q_push,
   output cad_pkg::cad_item_type             q_item
);
   import cad_pkg::*;

   logic                 unit_ff, unit_in;
   logic                 vld_ff, vld_in;
   cad_item_type         item_ff, item_in;
   logic                 accept;
   logic                 csr_wr;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic signed [XW-1:0] ax;

   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      unit_in = unit_ff;
      if (csr_wr && paddr[CSR_ADDR_W-1 -: CSR_IDX_W] == CSR_ANGLE_UNIT) begin
         unit_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1 -: CSR_IDX_W] == CSR_ANGLE_UNIT) begin
         prdata[0] = unit_ff;
      end
   end

   // one stage holds the classified item until the queue takes it
   assign q_push        = vld_ff && !q_full;
   assign req_bus.ready = !vld_ff || !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign q_item        = item_ff;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (q_push) begin
         vld_in = 1'b0;
      end
   end

   // scale by 32, mirror x into the right half plane, pre-rotate by 90 degrees
   always_comb begin
      xs = {{(XW-IN_W-5){req_bus.x_in[IN_W-1]}}, req_bus.x_in, 5'b0};
      ys = {{(XW-IN_W-5){req_bus.y_in[IN_W-1]}}, req_bus.y_in, 5'b0};
      ax = req_bus.x_in[IN_W-1] ? -xs : xs;
      item_in.negated = req_bus.x_in[IN_W-1];
      item_in.dneg    = req_bus.y_in[IN_W-1];
      item_in.unit    = unit_ff;
      if (req_bus.y_in[IN_W-1]) begin
         item_in.x   = ys;
         item_in.y   = -ax;
         item_in.sum = -atan_deg(0);
      end else begin
         item_in.x   = -ys;
         item_in.y   = ax;
         item_in.sum = atan_deg(0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         unit_ff <= unit_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: design/cad_queue.sv
`include "cordic_atan2_degrees_macros.svh"

module cad_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cad_pkg::cad_item_type  push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output cad_pkg::cad_item_type  head_item
);
   import cad_pkg::*;

   cad_item_type      mem_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `CAD_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `CAD_ASSERT_NEXT(a_count_down, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)
   `CAD_ASSERT_ALWAYS(a_ptr_gap, clock, reset, QPTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])

endmodule

// File: design/cad_back.sv
`include "cordic_atan2_degrees_macros.svh"

module cad_back #(
   parameter int ITERATIONS = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  cad_pkg::cad_item_type  q_head,
   output logic                   q_pop,
   cad_rsp_if.source              rsp_bus
);
   import cad_pkg::*;

   localparam int STEPS = (ITERATIONS > MAX_STEPS) ? MAX_STEPS : ITERATIONS;

   cad_item_type         pipe_ff [0:STEPS];
   cad_item_type         pipe_in [0:STEPS];
   logic [STEPS:0]       pvld_ff, pvld_in;

   logic [FW-1:0]        fold_ff, fold_in;
   logic                 fold_unit_ff;
   logic                 fold_vld_ff;
   logic signed [SW-1:0] half_turn;
   logic signed [SW-1:0] wrapped;

   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [8:0]           deg_ff;
   logic                 mul_unit_ff;
   logic                 mul_vld_ff;

   logic [OUT_W-1:0]     angle_ff, angle_in;
   logic                 out_vld_ff;
   logic                 enable;

   // whole pipe moves together, the result register decides
   assign enable = !out_vld_ff || rsp_bus.ready;
   assign q_pop  = enable && !q_empty;

   assign pipe_in[0] = q_head;
   assign pvld_in    = {pvld_ff[STEPS-1:0], q_pop};

   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      assign pipe_in[k] = cad_step(pipe_ff[k-1], unsigned'(k - 1), atan_deg(unsigned'(k)));
   end

   // fold to 0..360, result may run slightly past 360
   always_comb begin
      half_turn = pipe_ff[STEPS].negated ? pipe_ff[STEPS].sum : DEG_180 - pipe_ff[STEPS].sum;
      wrapped   = half_turn[SW-1] ? half_turn + DEG_360 : half_turn;
      fold_in   = wrapped[FW-1:0];
   end

   assign prod_in  = PROD_W'(fold_ff[FW-1:3]) * PROD_W'(DIV_MULT);
   assign angle_in = mul_unit_ff ? prod_ff[DIV_SHIFT +: OUT_W] : OUT_W'(deg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff     <= '0;
         fold_vld_ff <= 1'b0;
         mul_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else if (enable) begin
         pvld_ff     <= pvld_in;
         fold_vld_ff <= pvld_ff[STEPS];
         mul_vld_ff  <= fold_vld_ff;
         out_vld_ff  <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= STEPS; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
         fold_ff      <= fold_in;
         fold_unit_ff <= pipe_ff[STEPS].unit;
         prod_ff      <= prod_in;
         deg_ff       <= fold_ff[FW-1:16];
         mul_unit_ff  <= fold_unit_ff;
         angle_ff     <= angle_in;
      end
   end

   assign rsp_bus.valid     = out_vld_ff;
   assign rsp_bus.angle_out = angle_ff;

   `CAD_ASSERT_NEXT(a_stall_freezes, clock, reset, out_vld_ff && !rsp_bus.ready, $stable(pvld_ff))

endmodule

// File: design/cordic_atan2_degrees.sv
// channel   dir  fields                      transfer when
// req_bus   in   x_in s16, y_in s16 (6.10)   valid && ready
// rsp_bus   out  angle_out u16               valid && ready
// apb csr   in   angle_unit at byte 0        psel && penable && pwrite
//
// one vector per cycle while rsp_bus is ready; a vector passes through the
// input stage, queue, pipe entry, one stage per micro-rotation, fold,
// reciprocal multiply and result register
// reset is synchronous and clears angle_unit to degrees and empties the pipe
// a stalled result freezes the back pipe; the 4-entry queue and input stage
// keep taking vectors until they fill
module cordic_atan2_degrees #(
   parameter int ITERATIONS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   cad_req_if.sink                           req_bus,
   cad_rsp_if.source                         rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cad_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [cad_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cad_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import cad_pkg::*;

   logic         q_full;
   logic         q_push;
   logic         q_pop;
   logic         q_empty;
   cad_item_type q_item;
   cad_item_type q_head;

   assign pready = 1'b1;

   cad_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_item  (q_item)
   );

   cad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head)
   );

   cad_back #(
      .ITERATIONS (ITERATIONS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule
